### rtl/spd_pkg.sv
package spd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DIST_W         = 33;
  localparam int MUL_CHUNK      = 32;

endpackage

### rtl/spd_if.sv
interface spd_in_if import spd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface spd_out_if import spd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              segments_touch;
  logic [DIST_W-1:0] distance;

  modport source (output valid, segments_touch, distance, input ready);
  modport sink (input valid, segments_touch, distance, output ready);
endinterface

### rtl/spd_div.sv
module spd_div import spd_pkg::*; #(
  parameter int DEN_W = 2 * COORD_BITS_DEF + 2,
  parameter int QUO_W = 2 * COORD_BITS_DEF + 2 + 2 * FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  logic [DEN_W-1:0] rem_r [QUO_W-1];
  logic [DEN_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] dq_r  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] dq_in;
    logic [DEN_W:0]   t;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num[DEN_W+QUO_W-1:QUO_W];
      assign den_in = den;
      assign dq_in  = num[QUO_W-1:0];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign dq_in  = dq_r[i-1];
    end

    assign t  = {rem_in, dq_in[QUO_W-1]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[i] <= {dq_in[QUO_W-2:0], ge};
      end
    end

    if (i < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = dq_r[QUO_W-1];

endmodule

### rtl/spd_sqrt.sv
module spd_sqrt import spd_pkg::*; #(
  parameter int RAD_W  = 2 * COORD_BITS_DEF + 2 + 2 * FRAC_BITS_DEF,
  parameter int ROOT_W = (RAD_W + 1) / 2
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 1;
  localparam int PAD_W = 2 * ROOT_W;

  logic [REM_W-1:0]  rem_r  [ROOT_W-1];
  logic [PAD_W-1:0]  rad_r  [ROOT_W-1];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [PAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = PAD_W'(rad);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign t     = {rem_in, rad_in[PAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (i < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? REM_W'(t - trial) : REM_W'(t);
          rad_r[i] <= rad_in << 2;
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

### rtl/segment_pair_distance.sv
// channel  role    beat fields
// in_ch    sink    a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y (COORD_BITS, signed)
// out_ch   source  segments_touch (1), distance (33, FRAC_BITS fraction bits)
//
// One pair enters per cycle while out_ch is not stalled; the divider and
// square-root pipelines resolve one bit per stage.
// Synchronous active-low reset clears the stage valid bits only.
// A result held on out_ch freezes every stage; in_ch.ready drops in that cycle.
module segment_pair_distance import spd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  spd_in_if.sink    in_ch,
  spd_out_if.source out_ch
);

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int SQW  = PW;
  localparam int QW   = SQW + 2 * FRAC_BITS;
  localparam int MW   = SQW + QW;
  localparam int RW   = (QW + 1) / 2;
  localparam int CSW  = 2 * SQW;
  localparam int K    = MUL_CHUNK;
  localparam int NCH  = (SQW + K - 1) / K;
  localparam int NST  = 8 + QW + RW;
  localparam int MIN1 = 6 + QW;

  localparam int VU  = 0;
  localparam int VV  = 1;
  localparam int VCA = 2;
  localparam int VDA = 3;
  localparam int VCB = 4;
  localparam int VDB = 5;

  localparam int DOT_P [8] = '{VCA, VCB, VDA, VDB, VCA, VDA, VCB, VDB};
  localparam int DOT_L [8] = '{VU, VU, VU, VU, VV, VV, VV, VV};
  localparam int CR_L  [4] = '{VU, VU, VV, VV};
  localparam int CR_P  [4] = '{VCA, VDA, VCA, VCB};

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } vec_t;

  function automatic logic rmeet(input logic signed [DW-1:0] p, input logic signed [DW-1:0] q,
                                 input logic signed [DW-1:0] r, input logic signed [DW-1:0] s);
    logic signed [DW-1:0] lo1, hi1, lo2, hi2;
    lo1 = (p > q) ? q : p;
    hi1 = (p > q) ? p : q;
    lo2 = (r > s) ? s : r;
    hi2 = (r > s) ? r : s;
    return !(lo1 > hi2 || lo2 > hi1);
  endfunction

  function automatic logic [SQW-1:0] umin(input logic [SQW-1:0] a, input logic [SQW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic             en;
  logic [NST-1:0]   vld_r;
  logic [NST-1:3]   tch_r;

  assign en          = !(vld_r[NST-1] && !out_ch.ready);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // stage 1: differences, range overlap
  logic signed [DW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  vec_t                 vec_nxt [6];
  vec_t                 vec_r   [6];
  logic                 xmeet_r, ymeet_r;

  assign ax = DW'(in_ch.a_start_x);
  assign ay = DW'(in_ch.a_start_y);
  assign bx = DW'(in_ch.a_end_x);
  assign by = DW'(in_ch.a_end_y);
  assign cx = DW'(in_ch.b_start_x);
  assign cy = DW'(in_ch.b_start_y);
  assign dx = DW'(in_ch.b_end_x);
  assign dy = DW'(in_ch.b_end_y);

  always_comb begin
    vec_nxt[VU]  = '{x: bx - ax, y: by - ay};
    vec_nxt[VV]  = '{x: dx - cx, y: dy - cy};
    vec_nxt[VCA] = '{x: cx - ax, y: cy - ay};
    vec_nxt[VDA] = '{x: dx - ax, y: dy - ay};
    vec_nxt[VCB] = '{x: cx - bx, y: cy - by};
    vec_nxt[VDB] = '{x: dx - bx, y: dy - by};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r   <= vec_nxt;
      xmeet_r <= rmeet(ax, bx, cx, dx);
      ymeet_r <= rmeet(ay, by, cy, dy);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] sqx_r [6];
  logic signed [PW-1:0] sqy_r [6];
  logic signed [PW-1:0] dxx_r [8];
  logic signed [PW-1:0] dyy_r [8];
  logic signed [PW-1:0] cp1_r [4];
  logic signed [PW-1:0] cp2_r [4];
  logic                 xmeet2_r, ymeet2_r, avert2_r;

  for (genvar i = 0; i < 6; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sqx_r[i] <= vec_r[i].x * vec_r[i].x;
        sqy_r[i] <= vec_r[i].y * vec_r[i].y;
      end
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_dot
    always_ff @(posedge clk) begin
      if (en) begin
        dxx_r[j] <= vec_r[DOT_P[j]].x * vec_r[DOT_L[j]].x;
        dyy_r[j] <= vec_r[DOT_P[j]].y * vec_r[DOT_L[j]].y;
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_cr
    always_ff @(posedge clk) begin
      if (en) begin
        cp1_r[k] <= vec_r[CR_L[k]].y * vec_r[CR_P[k]].x;
        cp2_r[k] <= vec_r[CR_L[k]].x * vec_r[CR_P[k]].y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xmeet2_r <= xmeet_r;
      ymeet2_r <= ymeet_r;
      avert2_r <= (vec_r[VU].x == '0);
    end
  end

  // stage 3: sums
  logic [SQW-1:0]       sq_r  [6];
  logic                 ge0_r [8];
  logic                 le0_r [8];
  logic signed [PW-1:0] cr_r  [4];
  logic                 xmeet3_r, ymeet3_r, avert3_r;

  for (genvar i = 0; i < 6; i++) begin : g_sqs
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i] <= SQW'(sqx_r[i] + sqy_r[i]);
      end
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_dots
    logic signed [PW-1:0] dsum;
    assign dsum = dxx_r[j] + dyy_r[j];
    always_ff @(posedge clk) begin
      if (en) begin
        ge0_r[j] <= !dsum[PW-1];
        le0_r[j] <= dsum[PW-1] || (dsum == '0);
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_crs
    always_ff @(posedge clk) begin
      if (en) begin
        cr_r[k] <= cp1_r[k] - cp2_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xmeet3_r <= xmeet2_r;
      ymeet3_r <= ymeet2_r;
      avert3_r <= avert2_r;
    end
  end

  // stage 4: touch decision, lane setup
  logic           cneg [4];
  logic           cpos [4];
  logic           touch_nxt;
  logic           ins_nxt [4];
  logic [SQW-1:0] msq_nxt [4];
  logic [SQW-1:0] l2_nxt  [4];
  logic           ins_r   [4];
  logic [SQW-1:0] msq_r   [4];
  logic [SQW-1:0] l2_r    [4];
  logic [SQW-1:0] acr_r   [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cneg[k] = cr_r[k][PW-1];
      cpos[k] = !cr_r[k][PW-1] && (cr_r[k] != '0);
    end
    if (!cneg[0] && !cpos[0] && !cneg[1] && !cpos[1] &&
        !cneg[2] && !cpos[2] && !cneg[3] && !cpos[3]) begin
      touch_nxt = avert3_r ? ymeet3_r : xmeet3_r;
    end else begin
      touch_nxt = !((cpos[0] && cpos[1]) || (cneg[0] && cneg[1])) &&
                  !((cpos[2] && cpos[3]) || (cneg[2] && cneg[3]));
    end
    ins_nxt[0] = ge0_r[0] && le0_r[1] && (sq_r[VU] != '0);
    ins_nxt[1] = ge0_r[2] && le0_r[3] && (sq_r[VU] != '0);
    ins_nxt[2] = le0_r[4] && ge0_r[5] && (sq_r[VV] != '0);
    ins_nxt[3] = le0_r[6] && ge0_r[7] && (sq_r[VV] != '0);
    msq_nxt[0] = umin(sq_r[VCA], sq_r[VCB]);
    msq_nxt[1] = umin(sq_r[VDA], sq_r[VDB]);
    msq_nxt[2] = umin(sq_r[VCA], sq_r[VDA]);
    msq_nxt[3] = umin(sq_r[VCB], sq_r[VDB]);
    l2_nxt[0]  = sq_r[VU];
    l2_nxt[1]  = sq_r[VU];
    l2_nxt[2]  = sq_r[VV];
    l2_nxt[3]  = sq_r[VV];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ins_r    <= ins_nxt;
      msq_r    <= msq_nxt;
      l2_r     <= l2_nxt;
      for (int k = 0; k < 4; k++) begin
        acr_r[k] <= cneg[k] ? SQW'(-cr_r[k]) : SQW'(cr_r[k]);
      end
    end
  end

  // stages 5 and 6: cross squared, divider operands
  logic [2*K-1:0]  pp_r    [4][NCH][NCH];
  logic            ins5_r  [4];
  logic [SQW-1:0]  msq5_r  [4];
  logic [SQW-1:0]  l25_r   [4];
  logic [MW-1:0]   num_r   [4];
  logic [SQW-1:0]  den_r   [4];
  logic [QW-1:0]   quo     [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [NCH*K-1:0] apad;
    logic [CSW-1:0]   crsq;

    assign apad = (NCH*K)'(acr_r[k]);

    for (genvar i = 0; i < NCH; i++) begin : g_pi
      for (genvar j = 0; j < NCH; j++) begin : g_pj
        always_ff @(posedge clk) begin
          if (en) begin
            pp_r[k][i][j] <= apad[i*K +: K] * apad[j*K +: K];
          end
        end
      end
    end

    always_comb begin
      crsq = '0;
      for (int i = 0; i < NCH; i++) begin
        for (int j = 0; j < NCH; j++) begin
          crsq = crsq + (CSW'(pp_r[k][i][j]) << (K * (i + j)));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ins5_r[k] <= ins_r[k];
        msq5_r[k] <= msq_r[k];
        l25_r[k]  <= l2_r[k];
        num_r[k]  <= ins5_r[k] ? (MW'(crsq) << (2 * FRAC_BITS))
                               : (MW'(msq5_r[k]) << (2 * FRAC_BITS));
        den_r[k]  <= ins5_r[k] ? l25_r[k] : SQW'(1);
      end
    end

    spd_div #(
      .DEN_W (SQW),
      .QUO_W (QW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[k]),
      .den (den_r[k]),
      .quo (quo[k])
    );
  end

  // minimum over lanes, then root
  logic [QW-1:0] m_r [2];
  logic [QW-1:0] mn_r;
  logic [RW-1:0] root;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= (quo[0] < quo[1]) ? quo[0] : quo[1];
      m_r[1] <= (quo[2] < quo[3]) ? quo[2] : quo[3];
      mn_r   <= tch_r[MIN1] ? '0 : ((m_r[0] < m_r[1]) ? m_r[0] : m_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tch_r <= {tch_r[NST-2:3], touch_nxt};
    end
  end

  spd_sqrt #(
    .RAD_W  (QW),
    .ROOT_W (RW)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (mn_r),
    .root (root)
  );

  assign out_ch.valid          = vld_r[NST-1];
  assign out_ch.segments_touch = tch_r[NST-1];
  assign out_ch.distance       = DIST_W'(root);

  a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.segments_touch |-> out_ch.distance == '0)
    else $error("touching pair with nonzero distance");

  a_apart_ends: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !tch_r[3] |-> msq_r[0] != '0 && msq_r[1] != '0 &&
                              msq_r[2] != '0 && msq_r[3] != '0)
    else $error("separate segments share an end point");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r) && tch_r == $past(tch_r))
    else $error("pipeline moved during stall");

endmodule
